// ===== hw/rtl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// SVPWM package
// Fixed-point constants, sector codes and shared types of the SVPWM compare
// generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam logic [16:0] SQRT3_Q16      = 17'd113512;
    localparam logic [16:0] SQRT3_BY_2_Q16 = 17'd56756;
    localparam int          FRAC_BITS      = 16;

    localparam int          CMP_WIDTH      = 15;
    localparam logic [14:0] CMP_MAX        = 15'h7fff;

    localparam logic [31:0] PERIOD_RESET   = 32'd4200;
    localparam int          TIME_SAT_BIT   = 62;

    localparam int          QUEUE_DEPTH    = 4;
    localparam int          QUEUE_AW       = $clog2(QUEUE_DEPTH);

    typedef logic [2:0] sector_t;

    localparam sector_t SECTOR_ZERO = 3'd0;
    localparam sector_t SECTOR_1    = 3'd1;
    localparam sector_t SECTOR_2    = 3'd2;
    localparam sector_t SECTOR_3    = 3'd3;
    localparam sector_t SECTOR_4    = 3'd4;
    localparam sector_t SECTOR_5    = 3'd5;
    localparam sector_t SECTOR_6    = 3'd6;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/svpwm_queue.sv =====
// ----------------------------------------------------------------------------
// SVPWM queue
// Short register queue between the classify front and the timing back.
// ----------------------------------------------------------------------------
module svpwm_queue
    import svpwm_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output queue_status_t        status
);

    logic [WIDTH-1:0]    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== hw/rtl/svpwm_front.sv =====
// ----------------------------------------------------------------------------
// SVPWM front
// Accepts voltage vectors, finds the sector and the two active projections.
// ----------------------------------------------------------------------------
module svpwm_front
    import svpwm_pkg::*;
#(
    parameter int VOLT_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [VOLT_WIDTH-1:0] valpha,
    input  logic signed [VOLT_WIDTH-1:0] vbeta,
    input  logic        [VOLT_WIDTH-1:0] udc,
    input  queue_status_t                queue_status,
    output logic                         push,
    output logic [VOLT_WIDTH+15:0]       proj_x,
    output logic [VOLT_WIDTH+15:0]       proj_y,
    output logic [VOLT_WIDTH-1:0]        udc_fix,
    output sector_t                      sector
);

    localparam int EW  = VOLT_WIDTH + 18;
    localparam int EUW = VOLT_WIDTH + 16;

    logic                         f1_valid_reg;
    logic signed [EW-1:0]         f1_u_reg;
    logic signed [VOLT_WIDTH-1:0] f1_vb_reg;
    logic [VOLT_WIDTH-1:0]        f1_udc_reg;

    logic                         f2_valid_reg;
    logic [EUW-1:0]               f2_x_reg;
    logic [EUW-1:0]               f2_y_reg;
    logic [VOLT_WIDTH-1:0]        f2_udc_reg;
    sector_t                      f2_sector_reg;

    logic                         en1;
    logic                         en2;
    logic signed [EW-1:0]         u_next;
    logic signed [EW-1:0]         hb;
    logic signed [EW-1:0]         bb;
    logic signed [EW-1:0]         p1;
    logic signed [EW-1:0]         p2;
    logic signed [EW-1:0]         p3;
    logic signed [EW-1:0]         p4;
    logic signed [EW-1:0]         p5;
    logic signed [EW-1:0]         p6;
    sector_t                      sector_next;
    logic [EUW-1:0]               x_next;
    logic [EUW-1:0]               y_next;

    function automatic logic [EUW-1:0] pos_part(input logic signed [EW-1:0] p);
        return (p > 0) ? p[EUW-1:0] : '0;
    endfunction

    assign push       = f2_valid_reg && !queue_status.full;
    assign en2        = !f2_valid_reg || push;
    assign en1        = !f1_valid_reg || en2;
    assign item_stall = !en1;

    assign u_next = EW'(valpha) * $signed({1'b0, SQRT3_BY_2_Q16});
    assign hb     = EW'(f1_vb_reg) <<< 15;
    assign bb     = EW'(f1_vb_reg) <<< 16;
    assign p1     = hb - f1_u_reg;
    assign p2     = f1_u_reg + hb;
    assign p3     = f1_u_reg - hb;
    assign p4     = -f1_u_reg - hb;
    assign p5     = bb;
    assign p6     = -bb;

    always_comb
    begin
        sector_next    = SECTOR_ZERO;
        sector_next[0] = (f1_vb_reg > 0);
        sector_next[1] = (p3 > 0);
        sector_next[2] = (p4 > 0);
        unique case (sector_next)
            SECTOR_1:
            begin
                x_next = pos_part(p1);
                y_next = pos_part(p2);
            end
            SECTOR_2:
            begin
                x_next = pos_part(p2);
                y_next = pos_part(p6);
            end
            SECTOR_3:
            begin
                x_next = pos_part(p3);
                y_next = pos_part(p5);
            end
            SECTOR_4:
            begin
                x_next = pos_part(p6);
                y_next = pos_part(p1);
            end
            SECTOR_5:
            begin
                x_next = pos_part(p5);
                y_next = pos_part(p4);
            end
            SECTOR_6:
            begin
                x_next = pos_part(p4);
                y_next = pos_part(p3);
            end
            default:
            begin
                x_next = '0;
                y_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                f1_valid_reg <= item_valid;
            end
            if (en2)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            f1_u_reg   <= u_next;
            f1_vb_reg  <= vbeta;
            f1_udc_reg <= (udc == '0) ? VOLT_WIDTH'(1) : udc;
        end
        if (en2)
        begin
            f2_x_reg      <= x_next;
            f2_y_reg      <= y_next;
            f2_udc_reg    <= f1_udc_reg;
            f2_sector_reg <= sector_next;
        end
    end

    assign proj_x  = f2_x_reg;
    assign proj_y  = f2_y_reg;
    assign udc_fix = f2_udc_reg;
    assign sector  = f2_sector_reg;

endmodule

// ===== hw/rtl/svpwm_div.sv =====
// ----------------------------------------------------------------------------
// SVPWM divider
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over one shared divisor, with a side payload kept in step.
// ----------------------------------------------------------------------------
module svpwm_div
    import svpwm_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int QUO_W = 16,
    parameter int PAY_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num_a,
    input  logic [NUM_W-1:0] num_b,
    input  logic [DEN_W-1:0] den,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo_a,
    output logic [QUO_W-1:0] quo_b,
    output logic [PAY_W-1:0] pay_out
);

    logic             valid_reg [QUO_W];
    logic [DEN_W-1:0] ra_reg    [QUO_W];
    logic [DEN_W-1:0] rb_reg    [QUO_W];
    logic [QUO_W-1:0] la_reg    [QUO_W];
    logic [QUO_W-1:0] lb_reg    [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [PAY_W-1:0] pay_reg   [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic             v_src;
        logic [DEN_W-1:0] ra_src;
        logic [DEN_W-1:0] rb_src;
        logic [QUO_W-1:0] la_src;
        logic [QUO_W-1:0] lb_src;
        logic [DEN_W-1:0] d_src;
        logic [PAY_W-1:0] p_src;
        logic [DEN_W:0]   ta;
        logic [DEN_W:0]   tb;
        logic             ga;
        logic             gb;

        if (s == 0)
        begin : g_first
            assign v_src  = in_valid;
            assign ra_src = DEN_W'(num_a >> QUO_W);
            assign rb_src = DEN_W'(num_b >> QUO_W);
            assign la_src = num_a[QUO_W-1:0];
            assign lb_src = num_b[QUO_W-1:0];
            assign d_src  = den;
            assign p_src  = pay_in;
        end
        else
        begin : g_next
            assign v_src  = valid_reg[s-1];
            assign ra_src = ra_reg[s-1];
            assign rb_src = rb_reg[s-1];
            assign la_src = la_reg[s-1];
            assign lb_src = lb_reg[s-1];
            assign d_src  = den_reg[s-1];
            assign p_src  = pay_reg[s-1];
        end

        assign ta = {ra_src, la_src[QUO_W-1]};
        assign tb = {rb_src, lb_src[QUO_W-1]};
        assign ga = (ta >= {1'b0, d_src});
        assign gb = (tb >= {1'b0, d_src});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[s]  <= ga ? DEN_W'(ta - {1'b0, d_src}) : DEN_W'(ta);
                rb_reg[s]  <= gb ? DEN_W'(tb - {1'b0, d_src}) : DEN_W'(tb);
                la_reg[s]  <= {la_src[QUO_W-2:0], ga};
                lb_reg[s]  <= {lb_src[QUO_W-2:0], gb};
                den_reg[s] <= d_src;
                pay_reg[s] <= p_src;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo_a     = la_reg[QUO_W-1];
    assign quo_b     = lb_reg[QUO_W-1];
    assign pay_out   = pay_reg[QUO_W-1];

endmodule

// ===== hw/rtl/svpwm_back.sv =====
// ----------------------------------------------------------------------------
// SVPWM back
// Scales the projections into active times, rescales on overmodulation and
// forms the three permuted compare values.
// ----------------------------------------------------------------------------
module svpwm_back
    import svpwm_pkg::*;
#(
    parameter int VOLT_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COUNT_WIDTH-1:0] period_count,
    input  queue_status_t          queue_status,
    output logic                   pop,
    input  logic [VOLT_WIDTH+15:0] proj_x,
    input  logic [VOLT_WIDTH+15:0] proj_y,
    input  logic [VOLT_WIDTH-1:0]  udc_fix,
    input  sector_t                sector_in,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [CMP_WIDTH-1:0]   compare_a,
    output logic [CMP_WIDTH-1:0]   compare_b,
    output logic [CMP_WIDTH-1:0]   compare_c,
    output logic [2:0]             sector,
    output logic                   overmodulated
);

    localparam int CW   = COUNT_WIDTH;
    localparam int EUW  = VOLT_WIDTH + 16;
    localparam int PXW  = EUW + 17;
    localparam int SW   = EUW + 1;
    localparam int NXW  = SW + CW;
    localparam int TW   = VOLT_WIDTH + CW + 1;
    localparam int MW   = TW + CW;
    localparam int PAY2 = 4 + 2 * CW;

    logic                  adv;

    logic                  b0_valid_reg;
    logic [EUW-1:0]        b0_x_reg;
    logic [EUW-1:0]        b0_y_reg;
    logic [VOLT_WIDTH-1:0] b0_udc_reg;
    sector_t               b0_sector_reg;

    logic                  b1_valid_reg;
    logic [PXW-1:0]        b1_px_reg;
    logic [PXW-1:0]        b1_py_reg;
    logic [VOLT_WIDTH-1:0] b1_udc_reg;
    sector_t               b1_sector_reg;

    logic                  b2_valid_reg;
    logic [NXW-1:0]        b2_nx_reg;
    logic [NXW-1:0]        b2_ny_reg;
    logic [VOLT_WIDTH-1:0] b2_udc_reg;
    sector_t               b2_sector_reg;

    logic                  d1_valid;
    logic [TW-1:0]         d1_qx;
    logic [TW-1:0]         d1_qy;
    logic [2:0]            d1_sector;
    logic [TW-1:0]         tx;
    logic [TW-1:0]         ty;
    logic [TW:0]           tsum;

    logic                  b3_valid_reg;
    logic [MW-1:0]         b3_mx_reg;
    logic [MW-1:0]         b3_my_reg;
    logic [TW:0]           b3_tsum_reg;
    logic                  b3_ovm_reg;
    logic [CW-1:0]         b3_tx_reg;
    logic [CW-1:0]         b3_ty_reg;
    sector_t               b3_sector_reg;

    logic                  d2_valid;
    logic [CW-1:0]         d2_qx;
    logic [CW-1:0]         d2_qy;
    logic [PAY2-1:0]       d2_pay;
    sector_t               d2_sector;
    logic                  d2_ovm;
    logic [CW-1:0]         rx;
    logic [CW-1:0]         ry;
    logic [CW-1:0]         t0;
    logic [CW-1:0]         ta;
    logic [CW-1:0]         tb;
    logic [CW-1:0]         tc;
    logic [CW-1:0]         ca;
    logic [CW-1:0]         cb;
    logic [CW-1:0]         cc;

    logic                  result_valid_reg;
    logic [CMP_WIDTH-1:0]  compare_a_reg;
    logic [CMP_WIDTH-1:0]  compare_b_reg;
    logic [CMP_WIDTH-1:0]  compare_c_reg;
    sector_t               sector_reg;
    logic                  overmodulated_reg;

    function automatic logic [CMP_WIDTH-1:0] sat_cmp(input logic [CW-1:0] v);
        logic [CW+CMP_WIDTH:0] ext;
        ext = {{(CMP_WIDTH+1){1'b0}}, v};
        return (ext > (CW+CMP_WIDTH+1)'(CMP_MAX)) ? CMP_MAX : CMP_WIDTH'(ext);
    endfunction

    assign adv = !result_valid_reg || !result_stall;
    assign pop = adv && !queue_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg     <= 1'b0;
            b1_valid_reg     <= 1'b0;
            b2_valid_reg     <= 1'b0;
            b3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b0_valid_reg     <= !queue_status.empty;
            b1_valid_reg     <= b0_valid_reg;
            b2_valid_reg     <= b1_valid_reg;
            b3_valid_reg     <= d1_valid;
            result_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_x_reg      <= proj_x;
            b0_y_reg      <= proj_y;
            b0_udc_reg    <= udc_fix;
            b0_sector_reg <= sector_in;

            b1_px_reg     <= PXW'(b0_x_reg) * PXW'(SQRT3_Q16);
            b1_py_reg     <= PXW'(b0_y_reg) * PXW'(SQRT3_Q16);
            b1_udc_reg    <= b0_udc_reg;
            b1_sector_reg <= b0_sector_reg;

            b2_nx_reg     <= NXW'(b1_px_reg[PXW-1:FRAC_BITS]) * NXW'(period_count);
            b2_ny_reg     <= NXW'(b1_py_reg[PXW-1:FRAC_BITS]) * NXW'(period_count);
            b2_udc_reg    <= b1_udc_reg;
            b2_sector_reg <= b1_sector_reg;

            b3_mx_reg     <= MW'(tx) * MW'(period_count);
            b3_my_reg     <= MW'(ty) * MW'(period_count);
            b3_tsum_reg   <= tsum;
            b3_ovm_reg    <= (tsum > (TW+1)'(period_count));
            b3_tx_reg     <= tx[CW-1:0];
            b3_ty_reg     <= ty[CW-1:0];
            b3_sector_reg <= d1_sector;

            compare_a_reg     <= sat_cmp(ca);
            compare_b_reg     <= sat_cmp(cb);
            compare_c_reg     <= sat_cmp(cc);
            sector_reg        <= d2_sector;
            overmodulated_reg <= d2_ovm;
        end
    end

    svpwm_div #(
        .NUM_W (TW),
        .DEN_W (VOLT_WIDTH),
        .QUO_W (TW),
        .PAY_W (3)
    ) u_div_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b2_valid_reg),
        .num_a     (b2_nx_reg[NXW-1:FRAC_BITS]),
        .num_b     (b2_ny_reg[NXW-1:FRAC_BITS]),
        .den       (b2_udc_reg),
        .pay_in    (b2_sector_reg),
        .out_valid (d1_valid),
        .quo_a     (d1_qx),
        .quo_b     (d1_qy),
        .pay_out   (d1_sector)
    );

    if (TW > TIME_SAT_BIT)
    begin : g_sat
        assign tx = (d1_qx[TW-1:TIME_SAT_BIT] != '0) ? (TW'(1) << TIME_SAT_BIT) : d1_qx;
        assign ty = (d1_qy[TW-1:TIME_SAT_BIT] != '0) ? (TW'(1) << TIME_SAT_BIT) : d1_qy;
    end
    else
    begin : g_nosat
        assign tx = d1_qx;
        assign ty = d1_qy;
    end

    assign tsum = {1'b0, tx} + {1'b0, ty};

    svpwm_div #(
        .NUM_W (MW),
        .DEN_W (TW + 1),
        .QUO_W (CW),
        .PAY_W (PAY2)
    ) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b3_valid_reg),
        .num_a     (b3_mx_reg),
        .num_b     (b3_my_reg),
        .den       (b3_tsum_reg),
        .pay_in    ({b3_sector_reg, b3_ovm_reg, b3_tx_reg, b3_ty_reg}),
        .out_valid (d2_valid),
        .quo_a     (d2_qx),
        .quo_b     (d2_qy),
        .pay_out   (d2_pay)
    );

    assign d2_sector = d2_pay[PAY2-1:PAY2-3];
    assign d2_ovm    = d2_pay[2*CW];
    assign rx        = d2_ovm ? d2_qx : d2_pay[2*CW-1:CW];
    assign ry        = d2_ovm ? d2_qy : d2_pay[CW-1:0];
    assign t0        = period_count - rx - ry;
    assign ta        = t0 >> 2;
    assign tb        = ta + (rx >> 1);
    assign tc        = tb + (ry >> 1);

    always_comb
    begin
        unique case (d2_sector)
            SECTOR_1:
            begin
                ca = tb; cb = ta; cc = tc;
            end
            SECTOR_2:
            begin
                ca = ta; cb = tc; cc = tb;
            end
            SECTOR_3:
            begin
                ca = ta; cb = tb; cc = tc;
            end
            SECTOR_4:
            begin
                ca = tc; cb = tb; cc = ta;
            end
            SECTOR_5:
            begin
                ca = tc; cb = ta; cc = tb;
            end
            SECTOR_6:
            begin
                ca = tb; cb = tc; cc = ta;
            end
            default:
            begin
                ca = ta; cb = ta; cc = ta;
            end
        endcase
    end

    assign result_valid  = result_valid_reg;
    assign compare_a     = compare_a_reg;
    assign compare_b     = compare_b_reg;
    assign compare_c     = compare_c_reg;
    assign sector        = sector_reg;
    assign overmodulated = overmodulated_reg;

endmodule

// ===== hw/rtl/svpwm_compare_generator.sv =====
// ----------------------------------------------------------------------------
// SVPWM compare generator
// Seven-segment space vector PWM: sector, active times, overmodulation
// rescale and centre-aligned compare values for three phases.
// ----------------------------------------------------------------------------
//  channel   signals                                   transfer when
//  item      item_valid, item_stall, valpha/vbeta/udc  valid & !stall
//  result    result_valid, result_stall, compare_*,    valid & !stall
//            sector, overmodulated
//  config    cfg_write, cfg_data (period_count)        cfg_write
//
//  One vector per cycle sustained while no result stall holds the back;
//  each vector passes through the two bit-per-stage dividers (time
//  scaling, then overmodulation rescale).
//  Reset clears all valid flags and loads period_count with 4200.
//  A result stall freezes the back pipeline; the queue absorbs the front.
// ----------------------------------------------------------------------------
module svpwm_compare_generator
    import svpwm_pkg::*;
#(
    parameter int VOLT_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [COUNT_WIDTH-1:0]       cfg_data,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [VOLT_WIDTH-1:0] valpha,
    input  logic signed [VOLT_WIDTH-1:0] vbeta,
    input  logic        [VOLT_WIDTH-1:0] udc,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [CMP_WIDTH-1:0]         compare_a,
    output logic [CMP_WIDTH-1:0]         compare_b,
    output logic [CMP_WIDTH-1:0]         compare_c,
    output logic [2:0]                   sector,
    output logic                         overmodulated
);

    localparam int EUW = VOLT_WIDTH + 16;
    localparam int QW  = 2 * EUW + VOLT_WIDTH + 3;

    logic [COUNT_WIDTH-1:0] period_count_reg;
    logic [COUNT_WIDTH-1:0] period_count_next;

    queue_status_t          queue_status;
    logic                   push;
    logic                   pop;
    logic [EUW-1:0]         f_x;
    logic [EUW-1:0]         f_y;
    logic [VOLT_WIDTH-1:0]  f_udc;
    sector_t                f_sector;
    logic [QW-1:0]          q_out;

    assign period_count_next = cfg_write ? cfg_data : period_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= COUNT_WIDTH'(PERIOD_RESET);
        end
        else
        begin
            period_count_reg <= period_count_next;
        end
    end

    svpwm_front #(
        .VOLT_WIDTH (VOLT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .valpha       (valpha),
        .vbeta        (vbeta),
        .udc          (udc),
        .queue_status (queue_status),
        .push         (push),
        .proj_x       (f_x),
        .proj_y       (f_y),
        .udc_fix      (f_udc),
        .sector       (f_sector)
    );

    svpwm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_x, f_y, f_udc, f_sector}),
        .pop       (pop),
        .pop_data  (q_out),
        .status    (queue_status)
    );

    svpwm_back #(
        .VOLT_WIDTH  (VOLT_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .period_count  (period_count_reg),
        .queue_status  (queue_status),
        .pop           (pop),
        .proj_x        (q_out[QW-1:QW-EUW]),
        .proj_y        (q_out[QW-EUW-1:VOLT_WIDTH+3]),
        .udc_fix       (q_out[VOLT_WIDTH+2:3]),
        .sector_in     (q_out[2:0]),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .compare_a     (compare_a),
        .compare_b     (compare_b),
        .compare_c     (compare_c),
        .sector        (sector),
        .overmodulated (overmodulated)
    );

endmodule

// ===== dv/svpwm_compare_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SVPWM compare checker
// Watches the item, result and configuration ports of the compare generator,
// predicts sector, compare values and overmodulation flag for every item
// transfer, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module svpwm_compare_checker
    import svpwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [15:0]        cfg_data,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic signed [15:0] valpha,
    input  logic signed [15:0] vbeta,
    input  logic        [15:0] udc,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [14:0]        compare_a,
    input  logic [14:0]        compare_b,
    input  logic [14:0]        compare_c,
    input  logic [2:0]         sector,
    input  logic               overmodulated,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [14:0] cmp_a;
        logic [14:0] cmp_b;
        logic [14:0] cmp_c;
        sector_t     sec;
        logic        ovm;
    } compare_set_t;

    compare_set_t      expected_compares[$];
    longint unsigned   period_copy;

    function automatic longint unsigned active_time(longint e, longint unsigned per,
                                                    longint unsigned bus);
        longint unsigned s;
        if (e <= 0)
        begin
            return 0;
        end
        s = (longint'(e) * longint'(SQRT3_Q16)) >> FRAC_BITS;
        return (s * per) / (bus << FRAC_BITS);
    endfunction

    function automatic logic [14:0] clamp_cmp(longint unsigned v);
        return (v > 64'(CMP_MAX)) ? CMP_MAX : v[14:0];
    endfunction

    function automatic compare_set_t predict_compares(longint va, longint vb,
                                                      longint unsigned bus,
                                                      longint unsigned per);
        compare_set_t    r;
        longint          u;
        longint          hb;
        longint          bb;
        sector_t         sec;
        longint unsigned tx;
        longint unsigned ty;
        longint unsigned tsum;
        longint unsigned ta;
        longint unsigned tb;
        longint unsigned tc;
        u   = va * longint'(SQRT3_BY_2_Q16);
        hb  = vb * 32768;
        bb  = vb * 65536;
        sec = SECTOR_ZERO;
        tx  = 0;
        ty  = 0;
        r.ovm = 1'b0;
        if (bus == 0)
        begin
            bus = 1;
        end
        if (vb > 0)
        begin
            sec[0] = 1'b1;
        end
        if (u - hb > 0)
        begin
            sec[1] = 1'b1;
        end
        if (-u - hb > 0)
        begin
            sec[2] = 1'b1;
        end
        case (sec)
            SECTOR_1: begin tx = active_time(-u + hb, per, bus); ty = active_time(u + hb, per, bus); end
            SECTOR_2: begin tx = active_time(u + hb, per, bus);  ty = active_time(-bb, per, bus); end
            SECTOR_3: begin tx = active_time(u - hb, per, bus);  ty = active_time(bb, per, bus); end
            SECTOR_4: begin tx = active_time(-bb, per, bus);     ty = active_time(-u + hb, per, bus); end
            SECTOR_5: begin tx = active_time(bb, per, bus);      ty = active_time(-u - hb, per, bus); end
            SECTOR_6: begin tx = active_time(-u - hb, per, bus); ty = active_time(u - hb, per, bus); end
            default: ;
        endcase
        tsum = tx + ty;
        if (tsum > per)
        begin
            tx = (tx * per) / tsum;
            ty = (ty * per) / tsum;
            r.ovm = 1'b1;
        end
        ta = (per - tx - ty) >> 2;
        tb = ta + (tx >> 1);
        tc = tb + (ty >> 1);
        case (sec)
            SECTOR_1: begin r.cmp_a = clamp_cmp(tb); r.cmp_b = clamp_cmp(ta); r.cmp_c = clamp_cmp(tc); end
            SECTOR_2: begin r.cmp_a = clamp_cmp(ta); r.cmp_b = clamp_cmp(tc); r.cmp_c = clamp_cmp(tb); end
            SECTOR_3: begin r.cmp_a = clamp_cmp(ta); r.cmp_b = clamp_cmp(tb); r.cmp_c = clamp_cmp(tc); end
            SECTOR_4: begin r.cmp_a = clamp_cmp(tc); r.cmp_b = clamp_cmp(tb); r.cmp_c = clamp_cmp(ta); end
            SECTOR_5: begin r.cmp_a = clamp_cmp(tc); r.cmp_b = clamp_cmp(ta); r.cmp_c = clamp_cmp(tb); end
            SECTOR_6: begin r.cmp_a = clamp_cmp(tb); r.cmp_b = clamp_cmp(tc); r.cmp_c = clamp_cmp(ta); end
            default:  begin r.cmp_a = clamp_cmp(ta); r.cmp_b = clamp_cmp(ta); r.cmp_c = clamp_cmp(ta); end
        endcase
        r.sec = sec;
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        compare_set_t exp_set;
        if (!rst_n)
        begin
            period_copy = 64'(PERIOD_RESET[15:0]);
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_compares.size() == 0)
                begin
                    $display("%0t: unexpected result transfer a=%0d b=%0d c=%0d sector=%0d",
                             $time, compare_a, compare_b, compare_c, sector);
                    errors = errors + 1;
                end
                else
                begin
                    exp_set = expected_compares.pop_front();
                    if (compare_a !== exp_set.cmp_a || compare_b !== exp_set.cmp_b ||
                        compare_c !== exp_set.cmp_c || sector !== exp_set.sec ||
                        overmodulated !== exp_set.ovm)
                    begin
                        $display("%0t: mismatch expected a=%0d b=%0d c=%0d sector=%0d ovm=%0d",
                                 $time, exp_set.cmp_a, exp_set.cmp_b, exp_set.cmp_c,
                                 exp_set.sec, exp_set.ovm);
                        $display("%0t:          actual   a=%0d b=%0d c=%0d sector=%0d ovm=%0d",
                                 $time, compare_a, compare_b, compare_c, sector, overmodulated);
                        errors = errors + 1;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                expected_compares.push_back(predict_compares(longint'(valpha),
                                                             longint'(vbeta),
                                                             64'(udc), period_copy));
            end
            if (cfg_write)
            begin
                period_copy = 64'(cfg_data);
            end
        end
        pending = expected_compares.size();
    end

endmodule

// ===== dv/svpwm_compare_generator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SVPWM compare generator testbench
// Drives directed and random voltage vectors under several timer periods
// and idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module svpwm_compare_generator_test;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 80;
    localparam int PHASE_ITEMS = 315;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [15:0]        cfg_data;
    logic               item_valid;
    logic               item_stall;
    logic signed [15:0] valpha;
    logic signed [15:0] vbeta;
    logic        [15:0] udc;
    logic               result_valid;
    logic               result_stall;
    logic [14:0]        compare_a;
    logic [14:0]        compare_b;
    logic [14:0]        compare_c;
    logic [2:0]         sector;
    logic               overmodulated;
    int                 errors;
    int                 pending;
    int                 gap_pct;
    int                 stall_pct;
    int                 idle_cycles;

    svpwm_compare_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .valpha        (valpha),
        .vbeta         (vbeta),
        .udc           (udc),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .compare_a     (compare_a),
        .compare_b     (compare_b),
        .compare_c     (compare_c),
        .sector        (sector),
        .overmodulated (overmodulated)
    );

    svpwm_compare_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .valpha        (valpha),
        .vbeta         (vbeta),
        .udc           (udc),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .compare_a     (compare_a),
        .compare_b     (compare_b),
        .compare_c     (compare_c),
        .sector        (sector),
        .overmodulated (overmodulated),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall = ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** svpwm_compare_generator: FAILED **");
            $finish;
        end
    end

    task automatic send_vector(logic signed [15:0] va, logic signed [15:0] vb,
                               logic [15:0] bus);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        valpha     = va;
        vbeta      = vb;
        udc        = bus;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_period(logic [15:0] per);
        cfg_write = 1'b1;
        cfg_data  = per;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic send_random_vector();
        logic [15:0] va;
        logic [15:0] vb;
        logic [15:0] bus;
        int          pick;
        pick = $urandom_range(0, 9);
        va   = 16'($urandom());
        vb   = 16'($urandom());
        bus  = 16'($urandom_range(1, 65535));
        if (pick == 0)
        begin
            va = '0;
            vb = '0;
        end
        else if (pick == 1)
        begin
            vb = '0;
        end
        else if (pick == 2)
        begin
            va = '0;
        end
        else if (pick <= 5)
        begin
            va  = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            vb  = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            bus = 16'($urandom_range(4096, 16384));
        end
        send_vector(va, vb, bus);
    endtask

    initial
    begin
        logic [15:0] per;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        valpha       = '0;
        vbeta        = '0;
        udc          = 16'd1;
        gap_pct      = 0;
        stall_pct    = 0;
        result_stall = 1'b0;
        idle_cycles  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_vector(16'sd0, 16'sd0, 16'd1);
        send_vector(16'sd32767, 16'sd0, 16'd1);
        send_vector(-16'sd32768, -16'sd32768, 16'd65535);
        send_vector(16'sd32767, 16'sd32767, 16'd1);
        send_vector(16'sd0, 16'sd32767, 16'd65535);
        send_vector(16'sd0, -16'sd32768, 16'd65535);
        send_vector(-16'sd32768, 16'sd0, 16'd40000);
        send_vector(16'sd1, 16'sd0, 16'd65535);
        send_vector(-16'sd1, 16'sd0, 16'd65535);
        send_vector(16'sd0, -16'sd1, 16'd100);
        send_vector(16'sd8660, 16'sd5000, 16'd40000);
        send_vector(16'sd0, 16'sd10000, 16'd40000);
        send_vector(-16'sd8660, 16'sd5000, 16'd40000);
        send_vector(-16'sd8660, -16'sd5000, 16'd40000);
        send_vector(16'sd0, -16'sd10000, 16'd40000);
        send_vector(16'sd8660, -16'sd5000, 16'd40000);
        drain_results();

        write_period(16'd65535);
        send_vector(16'sd32767, -16'sd32768, 16'd1);
        send_vector(16'sd1000, 16'sd1000, 16'd65535);
        send_vector(-16'sd20000, 16'sd12000, 16'd30000);
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0: per = 16'd1;
                1: per = 16'($urandom_range(2, 65534));
                default: per = 16'd65535;
            endcase
            write_period(per);
            case (phase / 2)
                0: begin gap_pct = 12; stall_pct = 50; end
                1: begin gap_pct = 50; stall_pct = 12; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            repeat (PHASE_ITEMS) send_random_vector();
            drain_results();
        end
        gap_pct   = 0;
        stall_pct = 0;

        if (errors == 0)
        begin
            $display("** svpwm_compare_generator: PASSED **");
        end
        else
        begin
            $display("** svpwm_compare_generator: FAILED **");
        end
        $finish;
    end

endmodule
